FILE: rtl/tfsc_pkg.sv
`timescale 1ns / 1ps

package tfsc_pkg;

   localparam int unsigned TempWidth     = 12;
   localparam int unsigned HoldWidth     = 16;
   localparam int unsigned RampWidth     = 3;
   localparam int unsigned SpeedWidth    = 2;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned MaxCmds       = 3;

   typedef logic [SpeedWidth-1:0] speed_type;

   localparam speed_type SPEED_OFF  = 2'd0;
   localparam speed_type SPEED_LOW  = 2'd1;
   localparam speed_type SPEED_MID  = 2'd2;
   localparam speed_type SPEED_HIGH = 2'd3;

   localparam logic [CsrIndexWidth-1:0] REG_HOT_HIGH_LIMIT  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_COLD_HIGH_LIMIT = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_HOT_MID_LIMIT   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_COLD_MID_LIMIT  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_HOLD_INTERVAL   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_RAMPDOWN_WINDOW = 3'd5;

   localparam logic signed [TempWidth-1:0] RST_HOT_HIGH_LIMIT  = 12'sd320;
   localparam logic signed [TempWidth-1:0] RST_COLD_HIGH_LIMIT = 12'sd190;
   localparam logic signed [TempWidth-1:0] RST_HOT_MID_LIMIT   = 12'sd290;
   localparam logic signed [TempWidth-1:0] RST_COLD_MID_LIMIT  = 12'sd200;
   localparam logic [HoldWidth-1:0]        RST_HOLD_INTERVAL   = 16'd300;
   localparam logic [RampWidth-1:0]        RST_RAMPDOWN_WINDOW = 3'd5;

   typedef struct packed {
      logic signed [TempWidth-1:0] hot_high_limit;
      logic signed [TempWidth-1:0] cold_high_limit;
      logic signed [TempWidth-1:0] hot_mid_limit;
      logic signed [TempWidth-1:0] cold_mid_limit;
      logic [HoldWidth-1:0]        hold_interval;
      logic [RampWidth-1:0]        rampdown_window;
   } cfg_type;

   typedef struct packed {
      logic                 prev_call_absent;
      speed_type            target_speed;
      speed_type            current_speed;
      logic [HoldWidth-1:0] hold_count;
      logic [RampWidth-1:0] rampdown_left;
   } state_type;

   typedef struct packed {
      logic [1:0]                  count;
      speed_type [MaxCmds-1:0]     speed;
   } cmd_set_type;

endpackage

FILE: rtl/tfsc_if.sv
`timescale 1ns / 1ps

interface tfsc_req_if;
   import tfsc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        call_absent;
   logic signed [TempWidth-1:0] temperature;

   modport source (output valid, call_absent, temperature, input ready);
   modport sink (input valid, call_absent, temperature, output ready);
endinterface

interface tfsc_rsp_if;
   import tfsc_pkg::*;

   logic      valid;
   logic      ready;
   logic      command_valid;
   speed_type fan_speed;
   speed_type blink_count;
   logic      last;

   modport source (output valid, command_valid, fan_speed, blink_count, last, input ready);
   modport sink (input valid, command_valid, fan_speed, blink_count, last, output ready);
endinterface

FILE: rtl/tfsc_step.sv
`timescale 1ns / 1ps

module tfsc_step (
   input  tfsc_pkg::cfg_type                          cfg,
   input  tfsc_pkg::state_type                        state,
   input  logic                                       call_absent,
   input  logic signed [tfsc_pkg::TempWidth-1:0]      temperature,
   output tfsc_pkg::state_type                        state_in,
   output tfsc_pkg::cmd_set_type                      cmds,
   output tfsc_pkg::speed_type                        blink_count
);
   import tfsc_pkg::*;

   speed_type            pick;
   logic [RampWidth-1:0] ramp_dec;

   assign ramp_dec = state.rampdown_left - 3'd1;

   always_comb begin
      if ($signed(temperature) >= $signed(cfg.hot_high_limit) ||
          $signed(temperature) <= $signed(cfg.cold_high_limit)) begin
         pick = SPEED_HIGH;
      end else if ($signed(temperature) >= $signed(cfg.hot_mid_limit) ||
                   $signed(temperature) <= $signed(cfg.cold_mid_limit)) begin
         pick = SPEED_MID;
      end else begin
         pick = SPEED_LOW;
      end
   end

   always_comb begin
      state_in    = state;
      cmds        = '0;
      blink_count = SPEED_OFF;
      if (!call_absent) begin
         state_in.rampdown_left = '0;
         blink_count            = state.target_speed;
         if (state.hold_count == '0) begin
            state_in.target_speed = pick;
            if (pick != state.current_speed) begin
               state_in.hold_count    = cfg.hold_interval;
               state_in.current_speed = pick;
               if (pick > state.current_speed) begin
                  // step up one level per command
                  cmds.count = pick - state.current_speed;
                  for (int k = 0; k < MaxCmds; k++) begin
                     cmds.speed[k] = state.current_speed + SpeedWidth'(k + 1);
                  end
               end else begin
                  cmds.count    = 2'd1;
                  cmds.speed[0] = pick;
               end
            end
         end else begin
            state_in.hold_count = state.hold_count - 16'd1;
         end
      end else begin
         if (!state.prev_call_absent) begin
            state_in.hold_count    = '0;
            state_in.rampdown_left = cfg.rampdown_window;
            if (state.target_speed != SPEED_LOW) begin
               cmds.count             = 2'd1;
               cmds.speed[0]          = SPEED_LOW;
               state_in.current_speed = SPEED_LOW;
            end
            if (cfg.rampdown_window == '0) begin
               state_in.current_speed = SPEED_OFF;
               if (state.target_speed != SPEED_LOW) begin
                  cmds.count    = 2'd2;
                  cmds.speed[1] = SPEED_OFF;
               end else begin
                  cmds.count    = 2'd1;
                  cmds.speed[0] = SPEED_OFF;
               end
            end
         end else if (state.rampdown_left != '0) begin
            state_in.rampdown_left = ramp_dec;
            if (ramp_dec == '0) begin
               cmds.count             = 2'd1;
               cmds.speed[0]          = SPEED_OFF;
               state_in.current_speed = SPEED_OFF;
            end
         end
         state_in.target_speed = SPEED_OFF;
      end
      state_in.prev_call_absent = call_absent;
   end

endmodule

FILE: rtl/thermostat_fan_speed_controller.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_chan  in   valid/ready    call_absent, temperature
// rsp_chan  out  valid/ready    command_valid, fan_speed, blink_count, last
// csr_*     in   csr_we only    csr_index, csr_wdata
//
// a tick is registered on entry, evaluated in one pass and loaded into the result buffer
// the result buffer sends one beat per cycle while rsp_chan is ready: 1 to 3 beats per tick;
// ticks with one beat flow at one per cycle while rsp_chan is ready
// the next tick is taken while the previous one's beats are still going out
// reset is synchronous and restores the register defaults and the controller state
// a stall on rsp_chan holds the current beat and fills the input register, then backs up req_chan

module thermostat_fan_speed_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   tfsc_req_if.sink                               req_chan,
   tfsc_rsp_if.source                             rsp_chan,
   input  logic                                   csr_we,
   input  logic [tfsc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [tfsc_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import tfsc_pkg::*;

   cfg_type                     cfg_ff;
   state_type                   state_ff;
   state_type                   state_in;
   logic                        in_valid_ff;
   logic                        in_absent_ff;
   logic signed [TempWidth-1:0] in_temp_ff;
   logic                        out_valid_ff;
   cmd_set_type                 out_cmd_ff;
   logic [1:0]                  out_idx_ff;
   speed_type                   out_blink_ff;
   cmd_set_type                 step_cmds;
   speed_type                   step_blink;
   logic                        out_done;
   logic                        move;
   speed_type                   cur_speed;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hot_high_limit  <= RST_HOT_HIGH_LIMIT;
         cfg_ff.cold_high_limit <= RST_COLD_HIGH_LIMIT;
         cfg_ff.hot_mid_limit   <= RST_HOT_MID_LIMIT;
         cfg_ff.cold_mid_limit  <= RST_COLD_MID_LIMIT;
         cfg_ff.hold_interval   <= RST_HOLD_INTERVAL;
         cfg_ff.rampdown_window <= RST_RAMPDOWN_WINDOW;
      end else if (csr_we) begin
         case (csr_index)
            REG_HOT_HIGH_LIMIT:  cfg_ff.hot_high_limit  <= csr_wdata[TempWidth-1:0];
            REG_COLD_HIGH_LIMIT: cfg_ff.cold_high_limit <= csr_wdata[TempWidth-1:0];
            REG_HOT_MID_LIMIT:   cfg_ff.hot_mid_limit   <= csr_wdata[TempWidth-1:0];
            REG_COLD_MID_LIMIT:  cfg_ff.cold_mid_limit  <= csr_wdata[TempWidth-1:0];
            REG_HOLD_INTERVAL:   cfg_ff.hold_interval   <= csr_wdata[HoldWidth-1:0];
            REG_RAMPDOWN_WINDOW: cfg_ff.rampdown_window <= csr_wdata[RampWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_done       = out_valid_ff && rsp_chan.ready && rsp_chan.last;
   assign move           = in_valid_ff && (!out_valid_ff || out_done);
   assign req_chan.ready = !in_valid_ff || move;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_absent_ff <= req_chan.call_absent;
         in_temp_ff   <= req_chan.temperature;
      end
   end

   tfsc_step u_step (
      .cfg         (cfg_ff),
      .state       (state_ff),
      .call_absent (in_absent_ff),
      .temperature (in_temp_ff),
      .state_in    (state_in),
      .cmds        (step_cmds),
      .blink_count (step_blink)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (move) begin
         state_ff <= state_in;
      end
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (out_done) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_cmd_ff   <= step_cmds;
         out_blink_ff <= step_blink;
         out_idx_ff   <= 2'd0;
      end else if (out_valid_ff && rsp_chan.ready) begin
         out_idx_ff <= out_idx_ff + 2'd1;
      end
   end

   always_comb begin
      case (out_idx_ff)
         2'd0:    cur_speed = out_cmd_ff.speed[0];
         2'd1:    cur_speed = out_cmd_ff.speed[1];
         2'd2:    cur_speed = out_cmd_ff.speed[2];
         default: cur_speed = SPEED_OFF;
      endcase
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.command_valid = out_cmd_ff.count != 2'd0;
   assign rsp_chan.fan_speed     = (out_cmd_ff.count == 2'd0) ? SPEED_OFF : cur_speed;
   assign rsp_chan.blink_count   = out_blink_ff;
   assign rsp_chan.last          = (out_cmd_ff.count == 2'd0) ||
                                   (out_idx_ff == out_cmd_ff.count - 2'd1);

   a_beats_continue: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last |=> rsp_chan.valid)
      else $error("tick ended before its last beat");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_idx_ff < out_cmd_ff.count) ||
                       (out_cmd_ff.count == 2'd0 && out_idx_ff == 2'd0))
      else $error("beat index beyond command count");

   a_final_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last && rsp_chan.command_valid
      |-> state_ff.current_speed == rsp_chan.fan_speed)
      else $error("last command differs from running speed");

   a_ramp_target: assert property (@(posedge clock) disable iff (reset)
      state_ff.rampdown_left != '0 |-> state_ff.target_speed == SPEED_OFF)
      else $error("target speed set during ramp-down");

endmodule
